@@ src/assert_macros.svh @@
// assertion macros shared by the raster scan waypoint generator modules
// no dependencies; define ASSERT_OFF to drop every check
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed: %m");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  `ASSERT_AT(lbl, clk, rst_n, !(expr))
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

@@ src/rswg_pkg.sv @@
// types, constants and helpers of the raster scan waypoint generator
// no dependencies; used by every module of the block
package rswg_pkg;

  localparam int MAX_STEPS  = 20;
  localparam int LEN_W      = 20;
  localparam int LIM_W      = 21;
  localparam int POS_W      = 22;
  localparam int CNT_W      = $clog2(MAX_STEPS + 1);
  localparam int ACC_W      = LEN_W + $clog2(MAX_STEPS + 2);
  localparam int YPOS_W     = (ACC_W > POS_W) ? ACC_W : POS_W + 1;
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = LIM_W;

  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_LEN_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_LEN_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_STEP_Y      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_DIR_MODE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL_LIMIT_X  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL_LIMIT_Y  = 3'd5;

  localparam logic [1:0] ST_WAYPOINT = 2'd0;
  localparam logic [1:0] ST_LIMIT    = 2'd1;
  localparam logic [1:0] ST_ROWS     = 2'd2;

  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  typedef struct packed {
    logic [LEN_W-1:0] origin_x;
    logic [LEN_W-1:0] origin_y;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             move_axis;
    logic [POS_W-1:0] target_pos;
    logic             last_move;
  } out_t;

  typedef struct packed {
    logic [LEN_W-1:0] scan_len_x;
    logic [LEN_W-1:0] scan_len_y;
    logic [LEN_W-1:0] row_step_y;
    logic             single_dir_mode;
    logic [LIM_W-1:0] travel_limit_x;
    logic [LIM_W-1:0] travel_limit_y;
  } cfg_t;

  // one classified start request
  typedef struct packed {
    logic [1:0]       status;
    logic [LEN_W-1:0] origin_x;
    logic [LEN_W-1:0] origin_y;
    logic [LIM_W-1:0] x_end;
    logic [CNT_W-1:0] steps;
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_REFUSE,
    B_X0,
    B_Y0,
    B_SWEEP,
    B_RET,
    B_YSTEP
  } back_state_t;

  function automatic logic [POS_W-1:0] sat_pos(input logic [YPOS_W-1:0] v);
    logic [POS_W-1:0] res;
    if (|v[YPOS_W-1:POS_W]) begin
      res = POS_MAX;
    end else begin
      res = v[POS_W-1:0];
    end
    return res;
  endfunction

endpackage

@@ src/rswg_front.sv @@
// front end: takes start requests, checks travel limits, counts rows serially
// depends on rswg_pkg and assert_macros.svh
`include "assert_macros.svh"
module rswg_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rswg_pkg::cfg_t        cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rswg_pkg::in_t         in_data,
  output logic                  push_valid,
  input  logic                  push_ready,
  output rswg_pkg::job_t        push_job
);

  rswg_pkg::front_state_t              state_r, state_nxt;
  rswg_pkg::job_t                      job_r, job_nxt;
  logic [rswg_pkg::ACC_W-1:0]          acc_r, acc_nxt;
  logic [rswg_pkg::CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [rswg_pkg::LIM_W-1:0]          x_end_w;
  logic [rswg_pkg::LIM_W-1:0]          y_end_w;
  logic                                lim_fail;
  logic                                div_done;
  logic                                cnt_max;

  assign x_end_w  = rswg_pkg::LIM_W'(in_data.origin_x) + rswg_pkg::LIM_W'(cfg.scan_len_x);
  assign y_end_w  = rswg_pkg::LIM_W'(in_data.origin_y) + rswg_pkg::LIM_W'(cfg.scan_len_y);
  assign lim_fail = (x_end_w > cfg.travel_limit_x) || (y_end_w > cfg.travel_limit_y);
  assign div_done = acc_r >= rswg_pkg::ACC_W'(cfg.scan_len_y);
  assign cnt_max  = cnt_r == rswg_pkg::CNT_W'(rswg_pkg::MAX_STEPS);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rswg_pkg::F_IDLE: begin
        if (in_valid) begin
          if (lim_fail || cfg.row_step_y == '0) begin
            state_nxt = rswg_pkg::F_PUSH;
          end else begin
            state_nxt = rswg_pkg::F_DIV;
          end
        end
      end
      rswg_pkg::F_DIV: begin
        if (div_done || cnt_max) begin
          state_nxt = rswg_pkg::F_PUSH;
        end
      end
      rswg_pkg::F_PUSH: begin
        if (push_ready) begin
          state_nxt = rswg_pkg::F_IDLE;
        end
      end
      default: state_nxt = rswg_pkg::F_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready   = 1'b0;
    push_valid = 1'b0;
    case (state_r)
      rswg_pkg::F_IDLE: in_ready   = 1'b1;
      rswg_pkg::F_PUSH: push_valid = 1'b1;
      default: ;
    endcase
  end

  assign push_job = job_r;

  // row count by repeated addition of the step
  always_comb begin
    job_nxt = job_r;
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    case (state_r)
      rswg_pkg::F_IDLE: begin
        if (in_valid) begin
          job_nxt.origin_x = in_data.origin_x;
          job_nxt.origin_y = in_data.origin_y;
          job_nxt.x_end    = x_end_w;
          job_nxt.steps    = rswg_pkg::CNT_W'(1);
          job_nxt.status   = lim_fail ? rswg_pkg::ST_LIMIT : rswg_pkg::ST_WAYPOINT;
          acc_nxt          = rswg_pkg::ACC_W'(cfg.row_step_y);
          cnt_nxt          = rswg_pkg::CNT_W'(1);
        end
      end
      rswg_pkg::F_DIV: begin
        if (div_done) begin
          job_nxt.steps = cnt_r;
        end else if (cnt_max) begin
          job_nxt.status = rswg_pkg::ST_ROWS;
        end else begin
          acc_nxt = acc_r + rswg_pkg::ACC_W'(cfg.row_step_y);
          cnt_nxt = cnt_r + rswg_pkg::CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rswg_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
  end

  `ASSERT_AT(a_div_cnt_range, clk, rst_n, (state_r == rswg_pkg::F_DIV) |-> (cnt_r != '0 && cnt_r <= rswg_pkg::CNT_W'(rswg_pkg::MAX_STEPS)))
  `ASSERT_AT(a_push_steps, clk, rst_n, (push_valid && push_job.status == rswg_pkg::ST_WAYPOINT) |-> (push_job.steps != '0 && push_job.steps <= rswg_pkg::CNT_W'(rswg_pkg::MAX_STEPS)))
  `ASSERT_AT(a_accept_busy, clk, rst_n, (in_valid && in_ready) |=> !in_ready)

endmodule

@@ src/rswg_queue.sv @@
// short job queue between the front end and the move emitter
// depends on rswg_pkg and assert_macros.svh
`include "assert_macros.svh"
module rswg_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  rswg_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output rswg_pkg::job_t pop_job
);

  rswg_pkg::job_t                 entry_r [rswg_pkg::Q_DEPTH];
  logic [rswg_pkg::Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [rswg_pkg::Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [rswg_pkg::Q_CNT_W-1:0]   count_r, count_nxt;
  logic                           push_fire;
  logic                           pop_fire;

  assign push_ready = count_r != rswg_pkg::Q_CNT_W'(rswg_pkg::Q_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_job    = entry_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_fire) begin
      if (wr_ptr_r == rswg_pkg::Q_PTR_W'(rswg_pkg::Q_DEPTH - 1)) begin
        wr_ptr_nxt = '0;
      end else begin
        wr_ptr_nxt = wr_ptr_r + rswg_pkg::Q_PTR_W'(1);
      end
    end
    if (pop_fire) begin
      if (rd_ptr_r == rswg_pkg::Q_PTR_W'(rswg_pkg::Q_DEPTH - 1)) begin
        rd_ptr_nxt = '0;
      end else begin
        rd_ptr_nxt = rd_ptr_r + rswg_pkg::Q_PTR_W'(1);
      end
    end
    if (push_fire && !pop_fire) begin
      count_nxt = count_r + rswg_pkg::Q_CNT_W'(1);
    end else if (pop_fire && !push_fire) begin
      count_nxt = count_r - rswg_pkg::Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  `ASSERT_AT(a_count_range, clk, rst_n, count_r <= rswg_pkg::Q_CNT_W'(rswg_pkg::Q_DEPTH))
  `ASSERT_AT(a_count_up, clk, rst_n, (push_fire && !pop_fire) |=> (count_r == $past(count_r) + rswg_pkg::Q_CNT_W'(1)))
  `ASSERT_AT(a_count_down, clk, rst_n, (pop_fire && !push_fire) |=> (count_r == $past(count_r) - rswg_pkg::Q_CNT_W'(1)))

endmodule

@@ src/rswg_back.sv @@
// back end: turns a job into its run of single-axis moves, one per cycle while the output is not stalled
// depends on rswg_pkg and assert_macros.svh
`include "assert_macros.svh"
module rswg_back (
  input  logic           clk,
  input  logic           rst_n,
  input  rswg_pkg::cfg_t cfg,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  rswg_pkg::job_t pop_job,
  output logic           out_valid,
  input  logic           out_ready,
  output rswg_pkg::out_t out_data
);

  rswg_pkg::back_state_t          state_r, state_nxt;
  rswg_pkg::job_t                 job_r;
  logic [rswg_pkg::CNT_W-1:0]     row_r;
  logic [rswg_pkg::YPOS_W-1:0]    ypos_r;
  logic                           out_valid_r;
  rswg_pkg::out_t                 out_data_r;
  rswg_pkg::out_t                 res;
  logic                           emit;
  logic                           adv;
  logic                           at_last_row;
  logic [rswg_pkg::CNT_W-1:0]     last_row;

  assign adv         = !out_valid_r || out_ready;
  assign last_row    = (job_r.steps == rswg_pkg::CNT_W'(1)) ? '0 : job_r.steps;
  assign at_last_row = row_r == last_row;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rswg_pkg::B_IDLE: begin
        if (pop_valid) begin
          if (pop_job.status == rswg_pkg::ST_WAYPOINT) begin
            state_nxt = rswg_pkg::B_X0;
          end else begin
            state_nxt = rswg_pkg::B_REFUSE;
          end
        end
      end
      rswg_pkg::B_REFUSE: if (adv) state_nxt = rswg_pkg::B_IDLE;
      rswg_pkg::B_X0:     if (adv) state_nxt = rswg_pkg::B_Y0;
      rswg_pkg::B_Y0:     if (adv) state_nxt = rswg_pkg::B_SWEEP;
      rswg_pkg::B_SWEEP: begin
        if (adv) begin
          if (cfg.single_dir_mode) begin
            state_nxt = rswg_pkg::B_RET;
          end else if (at_last_row) begin
            state_nxt = rswg_pkg::B_IDLE;
          end else begin
            state_nxt = rswg_pkg::B_YSTEP;
          end
        end
      end
      rswg_pkg::B_RET: begin
        if (adv) begin
          state_nxt = at_last_row ? rswg_pkg::B_IDLE : rswg_pkg::B_YSTEP;
        end
      end
      rswg_pkg::B_YSTEP:  if (adv) state_nxt = rswg_pkg::B_SWEEP;
      default: state_nxt = rswg_pkg::B_IDLE;
    endcase
  end

  // move for the current state
  always_comb begin
    pop_ready      = 1'b0;
    emit           = 1'b0;
    res.status     = rswg_pkg::ST_WAYPOINT;
    res.move_axis  = rswg_pkg::AXIS_X;
    res.target_pos = '0;
    res.last_move  = 1'b0;
    case (state_r)
      rswg_pkg::B_IDLE: pop_ready = 1'b1;
      rswg_pkg::B_REFUSE: begin
        emit          = adv;
        res.status    = job_r.status;
        res.last_move = 1'b1;
      end
      rswg_pkg::B_X0: begin
        emit           = adv;
        res.target_pos = rswg_pkg::POS_W'(job_r.origin_x);
      end
      rswg_pkg::B_Y0: begin
        emit           = adv;
        res.move_axis  = rswg_pkg::AXIS_Y;
        res.target_pos = rswg_pkg::POS_W'(job_r.origin_y);
      end
      rswg_pkg::B_SWEEP: begin
        emit = adv;
        if (cfg.single_dir_mode || !row_r[0]) begin
          res.target_pos = rswg_pkg::POS_W'(job_r.x_end);
        end else begin
          res.target_pos = rswg_pkg::POS_W'(job_r.origin_x);
        end
        res.last_move = !cfg.single_dir_mode && at_last_row;
      end
      rswg_pkg::B_RET: begin
        emit           = adv;
        res.target_pos = rswg_pkg::POS_W'(job_r.origin_x);
        res.last_move  = at_last_row;
      end
      rswg_pkg::B_YSTEP: begin
        emit           = adv;
        res.move_axis  = rswg_pkg::AXIS_Y;
        res.target_pos = rswg_pkg::sat_pos(ypos_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rswg_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (adv) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= res;
    end
    if (state_r == rswg_pkg::B_IDLE && pop_valid) begin
      job_r  <= pop_job;
      row_r  <= '0;
      ypos_r <= rswg_pkg::YPOS_W'(pop_job.origin_y) + rswg_pkg::YPOS_W'(cfg.row_step_y);
    end else if (state_r == rswg_pkg::B_YSTEP && adv) begin
      row_r  <= row_r + rswg_pkg::CNT_W'(1);
      ypos_r <= ypos_r + rswg_pkg::YPOS_W'(cfg.row_step_y);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_AT(a_refuse_last, clk, rst_n, (out_valid && out_data.status != rswg_pkg::ST_WAYPOINT) |-> out_data.last_move)
  `ASSERT_AT(a_row_range, clk, rst_n, (state_r == rswg_pkg::B_SWEEP || state_r == rswg_pkg::B_RET || state_r == rswg_pkg::B_YSTEP) |-> (row_r <= last_row))
  `ASSERT_NEVER(a_ystep_last, clk, rst_n, state_r == rswg_pkg::B_YSTEP && at_last_row)

endmodule

@@ src/raster_scan_waypoint_generator_top.sv @@
// top level of the raster scan waypoint generator: config registers and wiring
// depends on rswg_pkg, rswg_front, rswg_queue and rswg_back
//
// channel  direction  handshake            payload
// in       input      in_valid/in_ready    rswg_pkg::in_t (origin_x, origin_y)
// out      output     out_valid/out_ready  rswg_pkg::out_t (status, axis, target, last)
// cfg      input      cfg_valid/cfg_ready  cfg_index 3 bits, cfg_data 21 bits
//
// a start request is accepted and counts rows serially in the F_DIV state
// (none on a zero row step or a limit refusal) and then enters the two-entry job queue
// the back end loads a job in B_IDLE, then emits up to 64 moves, one per cycle unless stalled
// reset is synchronous and active low and clears control state and the config registers
// cfg_ready is always high; a stalled output holds the back end while the front end
// keeps counting into the queue while it has room
module raster_scan_waypoint_generator_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  rswg_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output rswg_pkg::out_t                      out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rswg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rswg_pkg::CFG_DATA_W-1:0]     cfg_data
);

  rswg_pkg::cfg_t cfg_r;
  logic           push_valid;
  logic           push_ready;
  rswg_pkg::job_t push_job;
  logic           pop_valid;
  logic           pop_ready;
  rswg_pkg::job_t pop_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        rswg_pkg::CFG_SCAN_LEN_X:      cfg_r.scan_len_x      <= cfg_data[rswg_pkg::LEN_W-1:0];
        rswg_pkg::CFG_SCAN_LEN_Y:      cfg_r.scan_len_y      <= cfg_data[rswg_pkg::LEN_W-1:0];
        rswg_pkg::CFG_ROW_STEP_Y:      cfg_r.row_step_y      <= cfg_data[rswg_pkg::LEN_W-1:0];
        rswg_pkg::CFG_SINGLE_DIR_MODE: cfg_r.single_dir_mode <= cfg_data[0];
        rswg_pkg::CFG_TRAVEL_LIMIT_X:  cfg_r.travel_limit_x  <= cfg_data[rswg_pkg::LIM_W-1:0];
        rswg_pkg::CFG_TRAVEL_LIMIT_Y:  cfg_r.travel_limit_y  <= cfg_data[rswg_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  rswg_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  rswg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  rswg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
